// ===== src/cmm_pkg.sv =====
// shared types, opcodes and constants for the cluster map mru cache
package cmm_pkg;

   localparam int CMM_DEFAULT_ENTRIES = 8;
   localparam int VOL_W               = 4;
   localparam int FIELD_W             = 28;

   typedef enum logic [1:0] {
      OP_LOOKUP   = 2'd0,
      OP_ADD      = 2'd1,
      OP_INV_FILE = 2'd2,
      OP_INV_VOL  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MODE_LOOKUP,
      MODE_ADD,
      MODE_INVAL
   } walk_mode_type;

   typedef struct packed {
      logic [VOL_W-1:0]   volume;
      logic [FIELD_W-1:0] start;
      logic [FIELD_W-1:0] index;
      logic [FIELD_W-1:0] disk;
   } entry_type;

   typedef struct packed {
      logic [VOL_W-1:0]   volume;
      logic [FIELD_W-1:0] start;
      logic [FIELD_W-1:0] target;
      logic [FIELD_W-1:0] known_index;
      logic [FIELD_W-1:0] known_disk;
      logic [FIELD_W-1:0] floor_index;
      logic               vol_only;
   } cmp_req_type;

   typedef struct packed {
      logic lookup_take;
      logic idx_eq_target;
      logic add_hit;
      logic disk_diff;
      logic inval_hit;
   } cmp_result_type;

endpackage

// ===== src/cmm_match_unit.sv =====
// shared entry compare unit: checks one cache entry against the current request
module cmm_match_unit (
   input  cmm_pkg::entry_type      entry,
   input  logic                    entry_valid,
   input  cmm_pkg::cmp_req_type    req,
   output cmm_pkg::cmp_result_type result
);
   import cmm_pkg::*;

   logic vol_hit;
   logic key_hit;

   always_comb begin
      vol_hit = entry_valid && (entry.volume == req.volume);
      key_hit = vol_hit && (entry.start == req.start);

      result.lookup_take   = key_hit && (entry.index <= req.target)
                             && (entry.index > req.floor_index);
      result.idx_eq_target = (entry.index == req.target);
      result.add_hit       = key_hit && (entry.index == req.known_index);
      result.disk_diff     = (entry.disk != req.known_disk);
      result.inval_hit     = req.vol_only ? vol_hit : key_hit;
   end

endmodule

// ===== src/cluster_map_mru_cache.sv =====
// top level of the cluster map mru cache: sequencer, entry memory and recency list
//
// Fully associative cache of (volume, start cluster, file index) -> disk cluster
// with CACHE_ENTRIES slots kept in most-recent-first order. Each request word
// yields exactly one response word. The block takes one request at a time:
// req_ready is high only while the sequencer is idle. Every request but a
// lookup with a zero start cluster walks the recency list one position per
// cycle through a single compare unit, reading the entry memory in the cycle
// before the compare. A lookup walks the whole list but stops early when the
// exact index is found, and one with a zero start cluster answers without a
// walk; an add stops at its matching entry; an invalidate walks the whole
// list; an add that meets the same key with a different disk cluster reports
// corruption and then runs a full invalidate walk. The walk length, and so the
// rate, is set by the one-entry-per-cycle compare unit. Lookups do not reorder
// the list; a matching add moves its entry to the front and a missing add
// replaces the least recent slot. Entry fields reset to nothing; only the
// per-slot valid bits and the recency list are reset, the list to slot order.
module cluster_map_mru_cache #(
   parameter int CACHE_ENTRIES = cmm_pkg::CMM_DEFAULT_ENTRIES
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_opcode,
   input  logic [cmm_pkg::VOL_W-1:0]   req_volume_id,
   input  logic [cmm_pkg::FIELD_W-1:0] req_start_cluster,
   input  logic [cmm_pkg::FIELD_W-1:0] req_target_index,
   input  logic [cmm_pkg::FIELD_W-1:0] req_known_index,
   input  logic [cmm_pkg::FIELD_W-1:0] req_known_disk_cluster,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [cmm_pkg::FIELD_W-1:0] rsp_best_index,
   output logic [cmm_pkg::FIELD_W-1:0] rsp_best_disk_cluster,
   output logic                        rsp_exact_hit,
   output logic                        rsp_corruption
);
   import cmm_pkg::*;

   localparam int SW = $clog2(CACHE_ENTRIES);
   localparam logic [SW-1:0] LAST_POS     = SW'(CACHE_ENTRIES - 1);
   localparam logic [SW-1:0] LAST_ADD_POS = SW'(CACHE_ENTRIES - 2);

   // sequencer state
   state_type     state_ff, state_in;
   walk_mode_type mode_ff, mode_in;

   // captured request word
   opcode_type          op_ff, op_in;
   logic [VOL_W-1:0]    vol_ff, vol_in;
   logic [FIELD_W-1:0]  start_ff, start_in;
   logic [FIELD_W-1:0]  target_ff, target_in;
   logic [FIELD_W-1:0]  kidx_ff, kidx_in;
   logic [FIELD_W-1:0]  kdisk_ff, kdisk_in;

   // running result
   logic [FIELD_W-1:0]  best_i_ff, best_i_in;
   logic [FIELD_W-1:0]  best_d_ff, best_d_in;
   logic                exact_ff, exact_in;
   logic                corrupt_ff, corrupt_in;

   // recency list (position 0 = most recent), walk copy and valid bits
   logic [SW-1:0] order_ff [CACHE_ENTRIES];
   logic [SW-1:0] order_in [CACHE_ENTRIES];
   logic [SW-1:0] scan_ff  [CACHE_ENTRIES];
   logic [SW-1:0] scan_in  [CACHE_ENTRIES];
   logic          valid_ff [CACHE_ENTRIES];
   logic          valid_in [CACHE_ENTRIES];

   // walk control: issue stage reads memory, eval stage compares
   logic [SW-1:0] issue_pos_ff, issue_pos_in;
   logic          issuing_ff, issuing_in;
   logic          eval_vld_ff, eval_vld_in;
   logic          rd_last_ff;
   logic [SW-1:0] rd_pos_ff;
   logic [SW-1:0] rd_slot_ff;
   logic          rd_valid_ff;
   entry_type     rd_entry_ff;

   // entry memory
   entry_type     mem [CACHE_ENTRIES];
   entry_type     fill_entry;
   logic          mem_we;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]  rsp_best_index_ff, rsp_best_disk_ff;
   logic                rsp_exact_ff, rsp_corrupt_ff;
   logic                rsp_load;

   // compare unit
   cmp_req_type    cmp_req;
   cmp_result_type cmp_res;

   // walk events
   logic          last_pos;
   logic          accept;
   logic          quick_lookup;
   logic          lookup_stop;
   logic          restart;
   logic          walk_fin;
   logic          fill;
   logic          mtf_en;
   logic [SW-1:0] mtf_pos;
   logic [SW-1:0] mtf_slot;
   logic          clr_en;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign quick_lookup = (opcode_type'(req_opcode) == OP_LOOKUP) && (req_start_cluster == '0);

   always_comb begin
      cmp_req.volume      = vol_ff;
      cmp_req.start       = start_ff;
      cmp_req.target      = target_ff;
      cmp_req.known_index = kidx_ff;
      cmp_req.known_disk  = kdisk_ff;
      cmp_req.floor_index = best_i_ff;
      cmp_req.vol_only    = (op_ff == OP_INV_VOL);
   end

   cmm_match_unit u_match (
      .entry       (rd_entry_ff),
      .entry_valid (rd_valid_ff),
      .req         (cmp_req),
      .result      (cmp_res)
   );

   // what the evaluated position decides
   always_comb begin
      last_pos    = (mode_ff == MODE_ADD) ? (issue_pos_ff == LAST_ADD_POS)
                                          : (issue_pos_ff == LAST_POS);
      lookup_stop = eval_vld_ff && (mode_ff == MODE_LOOKUP)
                    && cmp_res.lookup_take && cmp_res.idx_eq_target;
      restart     = eval_vld_ff && (mode_ff == MODE_ADD)
                    && cmp_res.add_hit && cmp_res.disk_diff;
      mtf_en      = 1'b0;
      mtf_pos     = rd_pos_ff;
      mtf_slot    = rd_slot_ff;
      fill        = eval_vld_ff && (mode_ff == MODE_ADD) && rd_last_ff && !cmp_res.add_hit;
      clr_en      = eval_vld_ff && (mode_ff == MODE_INVAL) && cmp_res.inval_hit;
      if (eval_vld_ff && (mode_ff == MODE_ADD) && cmp_res.add_hit && !cmp_res.disk_diff) begin
         mtf_en = 1'b1;
      end else if (fill) begin
         // least recent slot is overwritten and moved to the front
         mtf_en   = 1'b1;
         mtf_pos  = LAST_POS;
         mtf_slot = order_ff[CACHE_ENTRIES-1];
      end
      walk_fin = eval_vld_ff && !restart
                 && (rd_last_ff || lookup_stop
                     || ((mode_ff == MODE_ADD) && cmp_res.add_hit));
      rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
      mem_we   = fill;
      fill_entry.volume = vol_ff;
      fill_entry.start  = start_ff;
      fill_entry.index  = kidx_ff;
      fill_entry.disk   = kdisk_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = quick_lookup ? ST_DONE : ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_fin) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and walk control
   always_comb begin
      mode_in      = mode_ff;
      op_in        = op_ff;
      vol_in       = vol_ff;
      start_in     = start_ff;
      target_in    = target_ff;
      kidx_in      = kidx_ff;
      kdisk_in     = kdisk_ff;
      best_i_in    = best_i_ff;
      best_d_in    = best_d_ff;
      exact_in     = exact_ff;
      corrupt_in   = corrupt_ff;
      issue_pos_in = issue_pos_ff;
      issuing_in   = issuing_ff;
      eval_vld_in  = 1'b0;
      order_in     = order_ff;
      scan_in      = scan_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;

      if (accept) begin
         op_in        = opcode_type'(req_opcode);
         vol_in       = req_volume_id;
         start_in     = req_start_cluster;
         target_in    = req_target_index;
         kidx_in      = req_known_index;
         kdisk_in     = req_known_disk_cluster;
         exact_in     = 1'b0;
         corrupt_in   = 1'b0;
         scan_in      = order_ff;
         issue_pos_in = '0;
         issuing_in   = !quick_lookup;
         unique case (opcode_type'(req_opcode))
            OP_LOOKUP: begin
               mode_in   = MODE_LOOKUP;
               best_i_in = req_known_index;
               best_d_in = req_known_disk_cluster;
            end
            OP_ADD: begin
               mode_in   = MODE_ADD;
               best_i_in = '0;
               best_d_in = '0;
            end
            OP_INV_FILE, OP_INV_VOL: begin
               mode_in   = MODE_INVAL;
               best_i_in = '0;
               best_d_in = '0;
            end
            default: mode_in = MODE_INVAL;
         endcase
      end

      // issue stage: read the slot at the head of the walk copy
      if ((state_ff == ST_WALK) && issuing_ff) begin
         for (int q = 0; q < CACHE_ENTRIES - 1; q++) begin
            scan_in[q] = scan_ff[q+1];
         end
         issue_pos_in = issue_pos_ff + 1'b1;
         if (last_pos) begin
            issuing_in = 1'b0;
         end
         eval_vld_in = !(walk_fin || restart);
      end

      // eval stage
      if (eval_vld_ff && (mode_ff == MODE_LOOKUP) && cmp_res.lookup_take) begin
         best_i_in = rd_entry_ff.index;
         best_d_in = rd_entry_ff.disk;
         if (cmp_res.idx_eq_target) begin
            exact_in = 1'b1;
         end
      end
      if (walk_fin) begin
         issuing_in = 1'b0;
      end
      if (restart) begin
         // corruption: sweep the whole list clearing the file
         mode_in      = MODE_INVAL;
         corrupt_in   = 1'b1;
         scan_in      = order_ff;
         issue_pos_in = '0;
         issuing_in   = 1'b1;
      end
      if (clr_en) begin
         valid_in[rd_slot_ff] = 1'b0;
      end
      if (fill) begin
         valid_in[order_ff[CACHE_ENTRIES-1]] = 1'b1;
      end
      if (mtf_en) begin
         for (int q = 0; q < CACHE_ENTRIES; q++) begin
            if (q == 0) begin
               order_in[q] = mtf_slot;
            end else if (SW'(q) <= mtf_pos) begin
               order_in[q] = order_ff[q-1];
            end
         end
      end

      // response register
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_LOOKUP;
         issuing_ff   <= 1'b0;
         eval_vld_ff  <= 1'b0;
         issue_pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int q = 0; q < CACHE_ENTRIES; q++) begin
            order_ff[q] <= SW'(q);
            valid_ff[q] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         issuing_ff   <= issuing_in;
         eval_vld_ff  <= eval_vld_in;
         issue_pos_ff <= issue_pos_in;
         rsp_valid_ff <= rsp_valid_in;
         order_ff     <= order_in;
         valid_ff     <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      vol_ff     <= vol_in;
      start_ff   <= start_in;
      target_ff  <= target_in;
      kidx_ff    <= kidx_in;
      kdisk_ff   <= kdisk_in;
      best_i_ff  <= best_i_in;
      best_d_ff  <= best_d_in;
      exact_ff   <= exact_in;
      corrupt_ff <= corrupt_in;
      scan_ff    <= scan_in;
      rd_last_ff  <= last_pos;
      rd_pos_ff   <= issue_pos_ff;
      rd_slot_ff  <= scan_ff[0];
      rd_valid_ff <= valid_ff[scan_ff[0]];
      if (rsp_load) begin
         rsp_best_index_ff <= best_i_ff;
         rsp_best_disk_ff  <= best_d_ff;
         rsp_exact_ff      <= exact_ff;
         rsp_corrupt_ff    <= corrupt_ff;
      end
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[order_ff[CACHE_ENTRIES-1]] <= fill_entry;
      end
      rd_entry_ff <= mem[scan_ff[0]];
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_best_index        = rsp_best_index_ff;
   assign rsp_best_disk_cluster = rsp_best_disk_ff;
   assign rsp_exact_hit         = rsp_exact_ff;
   assign rsp_corruption        = rsp_corrupt_ff;

   // compares only happen inside a walk
   a_eval_in_walk : assert property (@(posedge clock) disable iff (reset)
      eval_vld_ff |-> (state_ff == ST_WALK))
      else $error("compare stage active outside walk");

   // an exact hit is always above a zero floor
   a_exact_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_exact_ff) |-> (rsp_best_index_ff != '0))
      else $error("exact hit with zero index");

   // corruption comes only from an add, which carries no lookup result
   a_corrupt_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_corrupt_ff) |-> (!rsp_exact_ff && (rsp_best_index_ff == '0)))
      else $error("corruption word carries lookup result");

   // a response is only loaded when the register is free or being drained
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && (state_ff != ST_IDLE
         || $past(state_ff) != ST_DONE)))
      else $error("pending response overwritten");

endmodule
